// ===== design/dcmlr_pkg.sv =====
// Package for the depth curve minimum liquidity ratio block.
// Holds the queue word type, the sequencer state type and fixed constants.
// No dependencies.
package dcmlr_pkg;

    localparam int unsigned QW = 48;   // Q24.24 field width
    localparam int unsigned NW = 64;   // Q40.24 notional width
    localparam int unsigned LW = 39;   // log2 value, 7 integer + 32 fraction bits

    localparam logic [NW-1:0] ALL_ONES    = '1;
    localparam logic [63:0]   BPS_LN2_Q16 = 64'd454260936;

    // One classified point, as passed from the front end to the back end
    typedef struct packed {
        logic [QW-1:0] cum_quantity;
        logic [QW-1:0] level_price;
        logic [QW-1:0] step;
        logic          skip;
        logic          last_point;
    } t_item;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NMUL,
        B_NMUL_W,
        B_NADD,
        B_NORM,
        B_SQ,
        B_SQ_W,
        B_BMUL,
        B_BMUL_W,
        B_DMUL,
        B_DMUL_W,
        B_DIV,
        B_FIN,
        B_OUT
    } t_bstate;

endpackage

// ===== design/dcmlr_mul.sv =====
// 64 x 64 -> 128 bit multiplier built from one 32 x 32 multiplier.
// Four partial products, one per cycle, registered before accumulation.
// Depends on nothing.
module dcmlr_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_busy,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a, r_b;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic [63:0]  r_prod;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic [31:0]  pa, pb;
    logic [1:0]   sh_code;
    logic [127:0] shifted;

    always_comb begin
        case (r_cnt)
            3'd0: begin pa = r_a[31:0];  pb = r_b[31:0];  sh_code = 2'd0; end
            3'd1: begin pa = r_a[31:0];  pb = r_b[63:32]; sh_code = 2'd1; end
            3'd2: begin pa = r_a[63:32]; pb = r_b[31:0];  sh_code = 2'd1; end
            default: begin pa = r_a[63:32]; pb = r_b[63:32]; sh_code = 2'd2; end
        endcase
        case (r_sh)
            2'd0:    shifted = {64'd0, r_prod};
            2'd1:    shifted = {32'd0, r_prod, 32'd0};
            default: shifted = {r_prod, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
            r_cnt  <= 3'd0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt != 3'd0) begin
                r_acc <= r_acc + shifted;
            end
            if (r_cnt != 3'd4) begin
                r_prod <= {32'd0, pa} * {32'd0, pb};
                r_sh   <= sh_code;
            end
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd4) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== design/dcmlr_fifo.sv =====
// Short word queue between the front end and the back end.
// Depends on dcmlr_pkg for the word type.
module dcmlr_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dcmlr_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output dcmlr_pkg::t_item o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dcmlr_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

// ===== design/dcmlr_front.sv =====
// Front end: accepts points, forms the quantity step and the skip flag.
// Depends on dcmlr_pkg for the word type.
module dcmlr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [47:0]      i_cum_quantity,
    input  logic [47:0]      i_level_price,
    input  logic             i_last_point,
    input  logic             i_queue_full,
    output logic             o_push,
    output dcmlr_pkg::t_item o_item
);

    logic [47:0] r_prev;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        o_item.cum_quantity = i_cum_quantity;
        o_item.level_price  = i_level_price;
        o_item.step         = i_cum_quantity - r_prev;
        o_item.skip         = (i_cum_quantity <= r_prev) || (i_level_price == 48'd0);
        o_item.last_point   = i_last_point;
    end

    // Remember the quantity on every point; drop it at the end of a side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (o_push) begin
            r_prev <= i_last_point ? 48'd0 : i_cum_quantity;
        end
    end

endmodule

// ===== design/dcmlr_back.sv =====
// Back end: notional, two fixed-point logs, delta, ratio division, minimum.
// Depends on dcmlr_pkg and dcmlr_mul.
module dcmlr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [47:0]      i_mid_price,
    input  logic             i_empty,
    input  dcmlr_pkg::t_item i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [63:0]      o_min_ratio,
    output logic             o_ratio_found
);

    dcmlr_pkg::t_bstate r_state, n_state;
    dcmlr_pkg::t_item   r_item;

    logic [63:0]  r_notional, r_best, r_delta, r_rem, r_lo, r_q, r_out_min;
    logic         r_any, r_lsel, r_out_valid, r_out_found;
    logic [38:0]  r_la, r_d;
    logic [127:0] r_x;
    logic [6:0]   r_s;
    logic [2:0]   r_k;
    logic [63:0]  r_m;
    logic [31:0]  r_f;
    logic [4:0]   r_i;
    logic [5:0]   r_dcnt;

    logic         mul_start, mul_busy, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_p;

    logic         nz;
    logic [127:0] xs;
    logic [6:0]   amt;
    logic [127:0] x_nxt;
    logic [6:0]   s_nxt;
    logic [64:0]  nsum;
    logic [63:0]  add_v, notional_new;
    logic [63:0]  m_sq, m_new;
    logic [31:0]  f_new;
    logic [38:0]  l_val, l_diff;
    logic [63:0]  delta_v;
    logic [64:0]  r65;
    logic         qbit;
    logic [63:0]  rem_new, q_new;
    logic         out_free;

    dcmlr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    // Normalising shift, one binary step per cycle
    always_comb begin
        case (r_k)
            3'd0: begin nz = (r_x[127:64] == 64'd0); xs = {r_x[63:0], 64'd0};
                amt = 7'd64; end
            3'd1: begin nz = (r_x[127:96] == 32'd0); xs = {r_x[95:0], 32'd0};
                amt = 7'd32; end
            3'd2: begin nz = (r_x[127:112] == 16'd0); xs = {r_x[111:0], 16'd0};
                amt = 7'd16; end
            3'd3: begin nz = (r_x[127:120] == 8'd0); xs = {r_x[119:0], 8'd0};
                amt = 7'd8; end
            3'd4: begin nz = (r_x[127:124] == 4'd0); xs = {r_x[123:0], 4'd0};
                amt = 7'd4; end
            3'd5: begin nz = (r_x[127:126] == 2'd0); xs = {r_x[125:0], 2'd0};
                amt = 7'd2; end
            default: begin nz = !r_x[127]; xs = {r_x[126:0], 1'b0}; amt = 7'd1; end
        endcase
        x_nxt = nz ? xs : r_x;
        s_nxt = nz ? (r_s + amt) : r_s;
    end

    always_comb begin
        add_v = (mul_p[127:88] != 40'd0) ? dcmlr_pkg::ALL_ONES : mul_p[87:24];
        nsum  = {1'b0, r_notional} + {1'b0, add_v};
        notional_new = nsum[64] ? dcmlr_pkg::ALL_ONES : nsum[63:0];

        m_sq  = mul_p[125:62];
        m_new = m_sq[63] ? {1'b0, m_sq[63:1]} : m_sq;
        f_new = r_f;
        f_new[r_i] = m_sq[63];
        l_val  = {7'd127 - r_s, f_new};
        l_diff = (r_la >= l_val) ? (r_la - l_val) : (l_val - r_la);

        delta_v = (mul_p[127:88] != 40'd0) ? dcmlr_pkg::ALL_ONES : mul_p[87:24];

        r65     = {r_rem, r_lo[63]};
        qbit    = (r65 >= {1'b0, r_delta});
        rem_new = qbit ? 64'(r65 - {1'b0, r_delta}) : r65[63:0];
        q_new   = {r_q[62:0], qbit};

        out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcmlr_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        mul_start = 1'b0;
        mul_a     = 64'd0;
        mul_b     = 64'd0;
        unique case (r_state)
            dcmlr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_head.skip ? dcmlr_pkg::B_FIN : dcmlr_pkg::B_NMUL;
                end
            end
            dcmlr_pkg::B_NMUL: begin
                mul_start = 1'b1;
                mul_a     = {16'd0, r_item.level_price};
                mul_b     = {16'd0, r_item.step};
                n_state   = dcmlr_pkg::B_NMUL_W;
            end
            dcmlr_pkg::B_NMUL_W: begin
                if (mul_done) begin
                    n_state = dcmlr_pkg::B_NADD;
                end
            end
            dcmlr_pkg::B_NADD: begin
                n_state = (notional_new == 64'd0 || i_mid_price == 48'd0) ?
                          dcmlr_pkg::B_FIN : dcmlr_pkg::B_NORM;
            end
            dcmlr_pkg::B_NORM: begin
                if (r_k == 3'd6) begin
                    n_state = dcmlr_pkg::B_SQ;
                end
            end
            dcmlr_pkg::B_SQ: begin
                mul_start = 1'b1;
                mul_a     = r_m;
                mul_b     = r_m;
                n_state   = dcmlr_pkg::B_SQ_W;
            end
            dcmlr_pkg::B_SQ_W: begin
                if (mul_done) begin
                    if (r_i != 5'd0) begin
                        n_state = dcmlr_pkg::B_SQ;
                    end else begin
                        n_state = r_lsel ? dcmlr_pkg::B_DMUL : dcmlr_pkg::B_BMUL;
                    end
                end
            end
            dcmlr_pkg::B_BMUL: begin
                mul_start = 1'b1;
                mul_a     = {16'd0, r_item.cum_quantity};
                mul_b     = {16'd0, i_mid_price};
                n_state   = dcmlr_pkg::B_BMUL_W;
            end
            dcmlr_pkg::B_BMUL_W: begin
                if (mul_done) begin
                    n_state = dcmlr_pkg::B_NORM;
                end
            end
            dcmlr_pkg::B_DMUL: begin
                mul_start = 1'b1;
                mul_a     = {25'd0, r_d};
                mul_b     = dcmlr_pkg::BPS_LN2_Q16;
                n_state   = dcmlr_pkg::B_DMUL_W;
            end
            dcmlr_pkg::B_DMUL_W: begin
                if (mul_done) begin
                    if (delta_v == 64'd0 || {40'd0, r_notional[63:40]} >= delta_v) begin
                        n_state = dcmlr_pkg::B_FIN;
                    end else begin
                        n_state = dcmlr_pkg::B_DIV;
                    end
                end
            end
            dcmlr_pkg::B_DIV: begin
                if (r_dcnt == 6'd63) begin
                    n_state = dcmlr_pkg::B_FIN;
                end
            end
            dcmlr_pkg::B_FIN: begin
                n_state = r_item.last_point ? dcmlr_pkg::B_OUT : dcmlr_pkg::B_IDLE;
            end
            dcmlr_pkg::B_OUT: begin
                if (out_free) begin
                    n_state = dcmlr_pkg::B_IDLE;
                end
            end
            default: n_state = dcmlr_pkg::B_IDLE;
        endcase
    end

    // Curve state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notional  <= '0;
            r_best      <= dcmlr_pkg::ALL_ONES;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == dcmlr_pkg::B_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                dcmlr_pkg::B_NADD: begin
                    r_notional <= notional_new;
                end
                dcmlr_pkg::B_DMUL_W: begin
                    if (mul_done && delta_v != 64'd0) begin
                        r_any <= 1'b1;
                    end
                end
                dcmlr_pkg::B_DIV: begin
                    if (r_dcnt == 6'd63 && q_new < r_best) begin
                        r_best <= q_new;
                    end
                end
                dcmlr_pkg::B_OUT: begin
                    if (out_free) begin
                        r_out_min   <= r_best;
                        r_out_found <= r_any;
                        r_notional  <= '0;
                        r_best      <= dcmlr_pkg::ALL_ONES;
                        r_any       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the log and division datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            dcmlr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    r_item <= i_head;
                end
            end
            dcmlr_pkg::B_NADD: begin
                r_x    <= {40'd0, notional_new, 24'd0};
                r_s    <= '0;
                r_k    <= '0;
                r_lsel <= 1'b0;
            end
            dcmlr_pkg::B_NORM: begin
                r_x <= x_nxt;
                r_s <= s_nxt;
                r_k <= r_k + 3'd1;
                if (r_k == 3'd6) begin
                    r_m <= {1'b0, x_nxt[127:65]};
                    r_f <= '0;
                    r_i <= 5'd31;
                end
            end
            dcmlr_pkg::B_SQ_W: begin
                if (mul_done) begin
                    r_m <= m_new;
                    r_f <= f_new;
                    r_i <= r_i - 5'd1;
                    if (r_i == 5'd0) begin
                        if (r_lsel) begin
                            r_d <= l_diff;
                        end else begin
                            r_la <= l_val;
                        end
                    end
                end
            end
            dcmlr_pkg::B_BMUL_W: begin
                if (mul_done) begin
                    r_x    <= mul_p;
                    r_s    <= '0;
                    r_k    <= '0;
                    r_lsel <= 1'b1;
                end
            end
            dcmlr_pkg::B_DMUL_W: begin
                r_delta <= delta_v;
                r_rem   <= {40'd0, r_notional[63:40]};
                r_lo    <= {r_notional[39:0], 24'd0};
                r_q     <= '0;
                r_dcnt  <= '0;
            end
            dcmlr_pkg::B_DIV: begin
                r_rem  <= rem_new;
                r_lo   <= {r_lo[62:0], 1'b0};
                r_q    <= q_new;
                r_dcnt <= r_dcnt + 6'd1;
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_ratio   = r_out_min;
    assign o_ratio_found = r_out_found;

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcmlr_pkg::B_NORM && r_k == 3'd6) |=> r_x[127])
        else $error("log operand not normalised");

    a_mant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcmlr_pkg::B_SQ) |-> (r_m[63:62] == 2'b01))
        else $error("log mantissa out of range");

    a_best_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dcmlr_pkg::B_OUT) |=> (r_best <= $past(r_best)))
        else $error("minimum rose inside a curve side");

endmodule

// ===== design/depth_curve_min_liquidity_ratio.sv =====
// Top level of the depth curve minimum liquidity ratio block.
// Depends on dcmlr_pkg, dcmlr_front, dcmlr_fifo and dcmlr_back.
//
//   channel | valid       | stall        | word
//   --------+-------------+--------------+-------------------------------------------
//   input   | i_in_valid  | o_in_stall   | i_cum_quantity, i_level_price, i_last_point
//   output  | o_out_valid | i_out_stall  | o_min_ratio, o_ratio_found
//   config  | i_cfg_we    | (none)       | i_cfg_data -> mid price
//
// Steps: a skipped point passes from idle straight to the finish state in the back
// end; for a full point each 64x64 product runs as four partial products on the
// shared 32x32 multiplier, the two logs need 32 squarings each, plus 7 normalising
// steps per log, and the division takes 64 steps.
// The squaring loop of the log takes most of the time of a full point.
// Reset: synchronous, active low; clears the queue, the curve state and mid price.
// Stalls: the front end stalls only when the queue is full; a held result in
// the output register blocks the back end only at the end of a curve side.
module depth_curve_min_liquidity_ratio #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [47:0] i_cum_quantity,
    input  logic [47:0] i_level_price,
    input  logic        i_last_point,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_min_ratio,
    output logic        o_ratio_found,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_data
);

    logic [47:0]      r_mid_price;
    logic             push, pop, q_full, q_empty;
    dcmlr_pkg::t_item push_item, head_item;

    // Hold the mid price; the user must write it only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_price <= '0;
        end else if (i_cfg_we) begin
            r_mid_price <= i_cfg_data;
        end
    end

    // Classify each point and remember its quantity
    dcmlr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cum_quantity (i_cum_quantity),
        .i_level_price  (i_level_price),
        .i_last_point   (i_last_point),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    // Decouple intake from the long arithmetic
    dcmlr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_item)
    );

    // Run notional, logs, delta and ratio; report at the end of a side
    dcmlr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mid_price   (r_mid_price),
        .i_empty       (q_empty),
        .i_head        (head_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_min_ratio   (o_min_ratio),
        .o_ratio_found (o_ratio_found)
    );

endmodule
